/* src/dcs_pkg.sv */
package dcs_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);

    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);

    localparam int RAD_W  = 66;
    localparam int ROOT_W = 33;
    localparam int DIV_W  = 33;
    localparam int CNT_W  = 6;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_SOLVE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_ZERO_DIST = 2'd1;
    localparam logic [1:0] ST_NO_MASS   = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_SOLVE,
        OP_READ
    } t_op;

    typedef struct packed {
        logic [1:0]         kind;
        logic [9:0]         first_index;
        logic [9:0]         second_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        inv_mass;
        logic               pin_flag;
        logic [31:0]        rest_length;
        logic [15:0]        stiffness;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [31:0]        out_inv_mass;
        logic               out_pinned;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr_a;
        logic [ADDR_W-1:0]  addr_b;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        inv_mass;
        logic               pin_flag;
        logic [31:0]        rest_length;
        logic [15:0]        stiffness;
    } t_cmd;

endpackage

/* src/dcs_front.sv */
module dcs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dcs_pkg::t_in  i_item,
    output logic          o_full,
    output logic          o_valid,
    output dcs_pkg::t_cmd o_cmd,
    input  logic          i_take
);
    import dcs_pkg::*;

    t_cmd                r_q [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr;
    logic [FQ_PTR_W-1:0] r_rd;
    logic [FQ_PTR_W:0]   r_count;
    t_cmd                n_cmd;
    logic                a_ok;
    logic                b_ok;
    logic                push_ok;
    logic                take_ok;

    always_comb begin
        a_ok = 32'(i_item.first_index) < 32'(MAX_PARTICLES);
        b_ok = 32'(i_item.second_index) < 32'(MAX_PARTICLES);
        n_cmd.op = OP_NONE;
        case (i_item.kind)
            KIND_WRITE: if (a_ok) n_cmd.op = OP_WRITE;
            KIND_SOLVE: if (a_ok && b_ok) n_cmd.op = OP_SOLVE;
            KIND_READ:  if (a_ok) n_cmd.op = OP_READ;
            default:    n_cmd.op = OP_NONE;
        endcase
        n_cmd.addr_a      = ADDR_W'(i_item.first_index);
        n_cmd.addr_b      = ADDR_W'(i_item.second_index);
        n_cmd.pos_x       = i_item.pos_x;
        n_cmd.pos_y       = i_item.pos_y;
        n_cmd.pos_z       = i_item.pos_z;
        n_cmd.inv_mass    = i_item.inv_mass;
        n_cmd.pin_flag    = i_item.pin_flag;
        n_cmd.rest_length = i_item.rest_length;
        n_cmd.stiffness   = i_item.stiffness;
    end

    assign o_full  = r_count == (FQ_PTR_W + 1)'(FQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_q[r_rd];
    assign push_ok = i_push && !o_full;
    assign take_ok = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) r_q[r_wr] <= n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) r_wr <= r_wr + 1'b1;
            if (take_ok) r_rd <= r_rd + 1'b1;
            if (push_ok && !take_ok) r_count <= r_count + 1'b1;
            else if (take_ok && !push_ok) r_count <= r_count - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_take_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> o_valid)
        else $error("command taken from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FQ_PTR_W + 1)'(FQ_DEPTH))
        else $error("command queue overflow");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !take_ok) |=> r_count == $past(r_count) + 1'b1)
        else $error("command queue count lost a transaction");
`endif

endmodule

/* src/dcs_isqrt.sv */
module dcs_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dcs_pkg::RAD_W-1:0]  i_rad,
    output logic                       o_done,
    output logic [dcs_pkg::ROOT_W-1:0] o_root
);
    import dcs_pkg::*;

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+2:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W+2:0] rem2;
    logic [ROOT_W+2:0] trial;
    logic              ge;

    always_comb begin
        rem2  = {r_rem[ROOT_W:0], r_rad[RAD_W-1 -: 2]};
        trial = {1'b0, r_root, 2'b01};
        ge    = rem2 >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= ge ? rem2 - trial : rem2;
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* src/dcs_div.sv */
module dcs_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [dcs_pkg::CNT_W-1:0] i_iters,
    input  logic [dcs_pkg::DIV_W-1:0] i_rem,
    input  logic [dcs_pkg::RAD_W-1:0] i_low,
    input  logic [dcs_pkg::DIV_W-1:0] i_den,
    output logic                      o_done,
    output logic [dcs_pkg::DIV_W-1:0] o_quot
);
    import dcs_pkg::*;

    logic [DIV_W-1:0] r_rem;
    logic [RAD_W-1:0] r_low;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   rem2;
    logic [DIV_W:0]   diff;
    logic             ge;

    always_comb begin
        rem2 = {r_rem, r_low[RAD_W-1]};
        diff = rem2 - {1'b0, r_den};
        ge   = rem2 >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_low <= i_low;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_low <= r_low << 1;
            r_rem <= ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* src/dcs_back.sv */
module dcs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dcs_pkg::t_cmd i_cmd,
    output logic          o_take,
    output logic          o_out_valid,
    output dcs_pkg::t_out o_out,
    input  logic          i_pop
);
    import dcs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_WR_P, S_RD, S_RD_W, S_RD_A, S_RD_B, S_LATCH, S_CHECK,
        S_SQ_MUL, S_SQ_ACC, S_SQRT_GO, S_SQRT_WAIT, S_ERR,
        S_K_MUL, S_K_GO, S_K_WAIT, S_T_MUL, S_T_GO, S_T_WAIT,
        S_MA_MUL, S_MA_APPLY, S_MB_MUL, S_MB_APPLY, S_WR_A, S_WR_B, S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [31:0]      inv;
        logic             pin;
    } t_particle;

    localparam logic [CNT_W-1:0] K_ITERS = CNT_W'(29);
    localparam logic [CNT_W-1:0] T_ITERS = CNT_W'(DIV_W);

    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic [31:0] r;
        if (v > 37'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -37'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    t_state            r_state;
    t_cmd              r_cmd;
    t_particle         r_pa;
    t_particle         r_pb;
    logic [2:0][32:0]  r_d;
    logic [32:0]       r_tot;
    logic [RAD_W-1:0]  r_acc;
    logic [ROOT_W-1:0] r_dist;
    logic [32:0]       r_emag;
    logic              r_eneg;
    logic [28:0]       r_ka;
    logic [28:0]       r_kb;
    logic [DIV_W-1:0]  r_t;
    logic [1:0]        r_ax;
    logic              r_side;
    logic [RAD_W-1:0]  r_prod;
    t_out              r_res;
    t_out              r_out;
    logic              r_out_valid;

    t_particle         r_mem [MAX_PARTICLES];
    t_particle         r_rdata;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    t_particle         mem_wdata;

    logic [32:0]        d_cur;
    logic [32:0]        d_mag;
    logic [2:0][32:0]   d_new;
    logic [32:0]        tot;
    logic [33:0]        e_val;
    logic [32:0]        mul_a;
    logic [32:0]        mul_b;
    logic [RAD_W-1:0]   prod;
    logic [62:0]        rnd;
    logic [34:0]        mag;
    logic signed [36:0] mv;
    logic signed [36:0] sum_a;
    logic signed [36:0] sum_b;
    logic [31:0]        pa_p;
    logic [31:0]        pb_p;

    logic             sq_start;
    logic             sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic             dv_start;
    logic             dv_done;
    logic [CNT_W-1:0] dv_iters;
    logic [DIV_W-1:0] dv_rem;
    logic [RAD_W-1:0] dv_low;
    logic [DIV_W-1:0] dv_den;
    logic [DIV_W-1:0] dv_quot;

    dcs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_acc),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    dcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_iters (dv_iters),
        .i_rem   (dv_rem),
        .i_low   (dv_low),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    always_comb begin
        d_cur = r_d[r_ax];
        d_mag = d_cur[32] ? (~d_cur + 33'd1) : d_cur;
        for (int i = 0; i < 3; i++) begin
            d_new[i] = {r_pb.pos[i][31], r_pb.pos[i]} - {r_pa.pos[i][31], r_pa.pos[i]};
        end
        tot   = {1'b0, r_pa.inv} + {1'b0, r_pb.inv};
        e_val = {1'b0, r_dist} - {2'b00, r_cmd.rest_length};

        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ_MUL: begin
                mul_a = d_mag;
                mul_b = d_mag;
            end
            S_K_MUL: begin
                mul_a = 33'(r_cmd.stiffness);
                mul_b = 33'(r_side ? r_pb.inv : r_pa.inv);
            end
            S_T_MUL: begin
                mul_a = d_mag;
                mul_b = r_emag;
            end
            S_MA_MUL: begin
                mul_a = r_t;
                mul_b = 33'(r_ka);
            end
            S_MB_MUL: begin
                mul_a = r_t;
                mul_b = 33'(r_kb);
            end
            default: ;
        endcase
        prod = mul_a * mul_b;

        rnd   = r_prod[62:0] + (63'd1 << 27);
        mag   = rnd[62:28];
        mv    = (d_cur[32] ^ r_eneg) ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        pa_p  = r_pa.pos[r_ax];
        pb_p  = r_pb.pos[r_ax];
        sum_a = $signed({{5{pa_p[31]}}, pa_p}) + mv;
        sum_b = $signed({{5{pb_p[31]}}, pb_p}) - mv;

        sq_start = r_state == S_SQRT_GO;
        dv_start = (r_state == S_K_GO) || (r_state == S_T_GO);
        if (r_state == S_K_GO) begin
            dv_iters = K_ITERS;
            dv_rem   = 33'(r_prod[47:16]);
            dv_low   = {r_prod[15:0], 13'd0, 37'd0};
            dv_den   = r_tot;
        end else begin
            dv_iters = T_ITERS;
            dv_rem   = r_prod[65:33];
            dv_low   = {r_prod[32:0], 33'd0};
            dv_den   = r_dist;
        end

        mem_addr  = r_cmd.addr_a;
        mem_we    = 1'b0;
        mem_wdata = r_pa;
        case (r_state)
            S_WR_P: begin
                mem_we           = 1'b1;
                mem_wdata.pos[0] = r_cmd.pos_x;
                mem_wdata.pos[1] = r_cmd.pos_y;
                mem_wdata.pos[2] = r_cmd.pos_z;
                mem_wdata.inv    = r_cmd.inv_mass;
                mem_wdata.pin    = r_cmd.pin_flag;
            end
            S_RD_B: mem_addr = r_cmd.addr_b;
            S_WR_A: mem_we = 1'b1;
            S_WR_B: begin
                mem_addr  = r_cmd.addr_b;
                mem_we    = 1'b1;
                mem_wdata = r_pb;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        r_rdata <= r_mem[mem_addr];
    end

    assign o_take = (r_state == S_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= prod;
            if (r_state == S_DONE && (!r_out_valid || i_pop)) r_out_valid <= 1'b1;
            else if (i_pop && r_out_valid) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_cmd;
                    r_res <= '0;
                    case (i_cmd.op)
                        OP_WRITE: r_state <= S_WR_P;
                        OP_READ:  r_state <= S_RD;
                        OP_SOLVE: r_state <= S_RD_A;
                        default:  r_state <= S_DONE;
                    endcase
                end
                S_WR_P: r_state <= S_DONE;
                S_RD:   r_state <= S_RD_W;
                S_RD_W: begin
                    r_res.out_x        <= r_rdata.pos[0];
                    r_res.out_y        <= r_rdata.pos[1];
                    r_res.out_z        <= r_rdata.pos[2];
                    r_res.out_inv_mass <= r_rdata.inv;
                    r_res.out_pinned   <= r_rdata.pin;
                    r_res.status       <= ST_DONE;
                    r_state            <= S_DONE;
                end
                S_RD_A: r_state <= S_RD_B;
                S_RD_B: begin
                    r_pa    <= r_rdata;
                    r_state <= S_LATCH;
                end
                S_LATCH: begin
                    r_pb    <= r_rdata;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_d   <= d_new;
                    r_tot <= tot;
                    r_acc <= '0;
                    r_ax  <= '0;
                    r_res.out_x <= r_pa.pos[0];
                    r_res.out_y <= r_pa.pos[1];
                    r_res.out_z <= r_pa.pos[2];
                    if (r_pa.pos == r_pb.pos) begin
                        r_res.status <= ST_ZERO_DIST;
                        r_state      <= S_DONE;
                    end else if (tot == '0) begin
                        r_res.status <= ST_NO_MASS;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_SQ_MUL;
                    end
                end
                S_SQ_MUL: r_state <= S_SQ_ACC;
                S_SQ_ACC: begin
                    r_acc <= r_acc + r_prod;
                    if (r_ax == 2'd2) begin
                        r_state <= S_SQRT_GO;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_SQ_MUL;
                    end
                end
                S_SQRT_GO: r_state <= S_SQRT_WAIT;
                S_SQRT_WAIT: if (sq_done) begin
                    r_dist  <= sq_root;
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_eneg  <= e_val[33];
                    r_emag  <= e_val[33] ? 33'(~e_val + 34'd1) : e_val[32:0];
                    r_side  <= 1'b0;
                    r_state <= S_K_MUL;
                end
                S_K_MUL: r_state <= S_K_GO;
                S_K_GO:  r_state <= S_K_WAIT;
                S_K_WAIT: if (dv_done) begin
                    if (!r_side) begin
                        r_ka    <= dv_quot[28:0];
                        r_side  <= 1'b1;
                        r_state <= S_K_MUL;
                    end else begin
                        r_kb    <= dv_quot[28:0];
                        r_ax    <= '0;
                        r_state <= S_T_MUL;
                    end
                end
                S_T_MUL: r_state <= S_T_GO;
                S_T_GO:  r_state <= S_T_WAIT;
                S_T_WAIT: if (dv_done) begin
                    r_t     <= dv_quot;
                    r_state <= S_MA_MUL;
                end
                S_MA_MUL: r_state <= S_MA_APPLY;
                S_MA_APPLY: begin
                    if (!r_pa.pin) r_pa.pos[r_ax] <= sat32(sum_a);
                    r_state <= S_MB_MUL;
                end
                S_MB_MUL: r_state <= S_MB_APPLY;
                S_MB_APPLY: begin
                    if (!r_pb.pin) r_pb.pos[r_ax] <= sat32(sum_b);
                    if (r_ax == 2'd2) begin
                        r_state <= S_WR_A;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_T_MUL;
                    end
                end
                S_WR_A: r_state <= S_WR_B;
                S_WR_B: begin
                    r_res.out_x  <= r_pa.pos[0];
                    r_res.out_y  <= r_pa.pos[1];
                    r_res.out_z  <= r_pa.pos[2];
                    r_res.status <= ST_DONE;
                    r_state      <= S_DONE;
                end
                S_DONE: if (!r_out_valid || i_pop) begin
                    r_out   <= r_res;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* src/distance_constraint_solver.sv */
// Channel   Direction  Handshake            Payload
// input     in         push / full          i_item   (dcs_pkg::t_in)
// result    out        pop / empty          o_result (dcs_pkg::t_out)
//
// Solve time is set by the bit-serial square root (33 steps) and the shared
// bit-serial divider: two gain quotients of 29 steps and three axis quotients of 33.
// One item is worked at a time; a 4-entry command queue keeps taking input meanwhile.
// A finished result stalls the sequencer until the output register is free.
// Reset is synchronous and clears queue and sequencer; the particle store is not cleared.
module distance_constraint_solver (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  dcs_pkg::t_in  i_item,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output dcs_pkg::t_out o_result
);
    import dcs_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;
    logic out_valid;

    dcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd),
        .i_take  (cmd_take)
    );

    dcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cmd_valid),
        .i_cmd       (cmd),
        .o_take      (cmd_take),
        .o_out_valid (out_valid),
        .o_out       (o_result),
        .i_pop       (pop)
    );

    assign empty = !out_valid;

endmodule
